[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tga_pkg.sv]
// ----------------------------------------------------------------------------
// tga_pkg
// Types and constants shared by the TGA stream decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_ID,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_PIXEL        = 3'd0,
		ST_EMPTY        = 3'd1,
		ST_UNSUPPORTED  = 3'd2,
		ST_SHORT_HEADER = 3'd3,
		ST_TRUNCATED    = 3'd4
	} status_t;

	// Header layout
	localparam logic [4:0] HEADER_LEN   = 5'd18;
	localparam logic [4:0] HB_ID_LEN    = 5'd0;
	localparam logic [4:0] HB_TYPE      = 5'd2;
	localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HB_DEPTH     = 5'd16;
	localparam logic [4:0] HB_DESC      = 5'd17;

	localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_24       = 8'd24;
	localparam logic [7:0] DEPTH_32       = 8'd32;
	localparam int unsigned DESC_TOP_BIT  = 5;     // descriptor bit 0x20
	localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] dest_column;
		logic [15:0] dest_row;
		logic [15:0] image_width;
		logic [15:0] image_height;
		status_t     status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

[hdl/tga_parser.sv]
// ----------------------------------------------------------------------------
// tga_parser
// Header/ID/pixel parse state and combinational result computation per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_parser import tga_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    accept,
	input  wire logic [7:0] data_byte,
	input  wire logic    first_byte,
	input  wire logic    final_byte,
	output logic         res_valid,
	output result_t      res,
	output phase_t       phase
);

	phase_t      phase_q;
	logic [4:0]  hidx_q;
	logic [7:0]  id_left_q;
	logic [7:0]  type_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  bpp_q;
	logic        top_q;
	logic [15:0] col_q;
	logic [15:0] row_q;
	logic [23:0] pix_q;
	logic [1:0]  bip_q;

	// current (after first-byte clear) and next values
	phase_t      c_phase, n_phase;
	logic [4:0]  c_hidx, n_hidx;
	logic [7:0]  c_id, n_id;
	logic [7:0]  c_type, n_type;
	logic [15:0] c_width, n_width;
	logic [15:0] c_height, n_height;
	logic [7:0]  c_bpp, n_bpp;
	logic        c_top, n_top;
	logic [15:0] c_col, n_col;
	logic [15:0] c_row, n_row;
	logic [23:0] c_pix, n_pix;
	logic [1:0]  c_bip, n_bip;

	logic        is32;
	logic        gather;
	logic [15:0] col_inc;
	logic        do_fail;
	status_t     fail_code;
	logic        fail_dims;
	logic        do_pix;
	logic        pix_last;

	always_comb begin
		c_phase  = first_byte ? PH_HEADER : phase_q;
		c_hidx   = first_byte ? '0 : hidx_q;
		c_id     = first_byte ? '0 : id_left_q;
		c_type   = first_byte ? '0 : type_q;
		c_width  = first_byte ? '0 : width_q;
		c_height = first_byte ? '0 : height_q;
		c_bpp    = first_byte ? '0 : bpp_q;
		c_top    = first_byte ? 1'b0 : top_q;
		c_col    = first_byte ? '0 : col_q;
		c_row    = first_byte ? '0 : row_q;
		c_pix    = first_byte ? '0 : pix_q;
		c_bip    = first_byte ? '0 : bip_q;

		n_phase  = c_phase;
		n_hidx   = c_hidx;
		n_id     = c_id;
		n_type   = c_type;
		n_width  = c_width;
		n_height = c_height;
		n_bpp    = c_bpp;
		n_top    = c_top;
		n_col    = c_col;
		n_row    = c_row;
		n_pix    = c_pix;
		n_bip    = c_bip;

		is32      = (c_bpp == DEPTH_32);
		gather    = is32 ? (c_bip < 2'd3) : (c_bip < 2'd2);
		col_inc   = c_col + 16'd1;
		do_fail   = 1'b0;
		fail_code = ST_PIXEL;
		fail_dims = 1'b1;
		do_pix    = 1'b0;
		pix_last  = 1'b0;

		unique case (c_phase)
			PH_HEADER: begin
				unique case (c_hidx)
					HB_ID_LEN:    n_id = data_byte;
					HB_TYPE:      n_type = data_byte;
					HB_WIDTH_LO:  n_width[7:0] = data_byte;
					HB_WIDTH_HI:  n_width[15:8] = data_byte;
					HB_HEIGHT_LO: n_height[7:0] = data_byte;
					HB_HEIGHT_HI: n_height[15:8] = data_byte;
					HB_DEPTH:     n_bpp = data_byte;
					HB_DESC:      n_top = data_byte[DESC_TOP_BIT];
					default: ;
				endcase
				n_hidx = c_hidx + 5'd1;
				if (n_hidx < HEADER_LEN) begin
					if (final_byte) begin
						do_fail   = 1'b1;
						fail_code = ST_SHORT_HEADER;
						fail_dims = 1'b0;
					end
				end else if (c_type != TYPE_TRUECOLOR ||
						(c_bpp != DEPTH_24 && c_bpp != DEPTH_32)) begin
					do_fail   = 1'b1;
					fail_code = ST_UNSUPPORTED;
				end else if (c_width == '0 || c_height == '0) begin
					do_fail   = 1'b1;
					fail_code = ST_EMPTY;
				end else begin
					n_phase = (c_id != '0) ? PH_ID : PH_PIXELS;
					if (final_byte) begin
						do_fail   = 1'b1;
						fail_code = ST_TRUNCATED;
					end
				end
			end
			PH_ID: begin
				n_id = c_id - 8'd1;
				if (n_id == '0)
					n_phase = PH_PIXELS;
				if (final_byte) begin
					do_fail   = 1'b1;
					fail_code = ST_TRUNCATED;
				end
			end
			PH_PIXELS: begin
				if (gather) begin
					case (c_bip)
						2'd0:    n_pix[7:0]   = data_byte;
						2'd1:    n_pix[15:8]  = data_byte;
						default: n_pix[23:16] = data_byte;
					endcase
					n_bip = c_bip + 2'd1;
					if (final_byte) begin
						do_fail   = 1'b1;
						fail_code = ST_TRUNCATED;
					end
				end else begin
					n_pix = '0;
					n_bip = '0;
					if (col_inc == c_width) begin
						n_col = '0;
						n_row = c_row + 16'd1;
					end else begin
						n_col = col_inc;
					end
					if (n_row == c_height) begin
						n_phase  = PH_DONE;
						do_pix   = 1'b1;
						pix_last = 1'b1;
					end else if (final_byte) begin
						do_fail   = 1'b1;
						fail_code = ST_TRUNCATED;
					end else begin
						do_pix = 1'b1;
					end
				end
			end
			default: ;
		endcase

		if (do_fail)
			n_phase = PH_DONE;
	end

	// Result assembly
	always_comb begin
		res       = '0;
		res_valid = do_fail | do_pix;
		if (do_pix) begin
			res.blue         = c_pix[7:0];
			res.green        = c_pix[15:8];
			res.red          = is32 ? c_pix[23:16] : data_byte;
			res.alpha        = is32 ? data_byte : ALPHA_OPAQUE;
			res.dest_column  = c_col;
			res.dest_row     = c_top ? (c_height - 16'd1 - c_row) : c_row;
			res.image_width  = c_width;
			res.image_height = c_height;
			res.status       = ST_PIXEL;
			res.last         = pix_last;
		end else if (do_fail) begin
			res.image_width  = fail_dims ? n_width : '0;
			res.image_height = fail_dims ? n_height : '0;
			res.status       = fail_code;
			res.last         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hidx_q    <= '0;
			id_left_q <= '0;
			type_q    <= '0;
			width_q   <= '0;
			height_q  <= '0;
			bpp_q     <= '0;
			top_q     <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			pix_q     <= '0;
			bip_q     <= '0;
		end else if (accept) begin
			phase_q   <= n_phase;
			hidx_q    <= n_hidx;
			id_left_q <= n_id;
			type_q    <= n_type;
			width_q   <= n_width;
			height_q  <= n_height;
			bpp_q     <= n_bpp;
			top_q     <= n_top;
			col_q     <= n_col;
			row_q     <= n_row;
			pix_q     <= n_pix;
			bip_q     <= n_bip;
		end
	end

	assign phase = phase_q;

endmodule

`default_nettype wire

[hdl/tga_out_reg.sv]
// ----------------------------------------------------------------------------
// tga_out_reg
// Result register; holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_out_reg import tga_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire logic    load_valid,
	input  wire result_t load_res,
	input  wire logic    out_ready,
	output logic         out_valid,
	output logic         free,
	output result_t      res
);

	logic    valid_q;
	result_t res_q;

	// free when empty or when the held result leaves this cycle
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			res_q <= load_res;
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[hdl/tga_truecolor_stream_decoder.sv]
// ----------------------------------------------------------------------------
// tga_truecolor_stream_decoder
// Streaming decoder for uncompressed 24/32-bit true-color TGA files.
// ----------------------------------------------------------------------------
// The file enters one byte per input transaction, with first_byte marking
// byte 0 (parsing restarts there, abandoning any file in progress) and
// final_byte marking the last byte available. The 18-byte header is parsed,
// the ID field skipped, and image type 2 at depth 24 or 32 is accepted. Each
// completed pixel leaves as one output transaction in RGBA order (alpha 255
// for 24-bit data) with its column and its bottom-up row, mirrored when
// descriptor bit 0x20 is set. Errors end the file with one status transaction
// (empty image, unsupported format, short header, truncated pixel data) that
// has last high; the final pixel also carries last. Bytes outside a file are
// taken and dropped. The parse state updates and the result is computed in
// the cycle the byte is accepted, and the result lands in the output
// register, so a byte can be taken every clock as long as the output
// register is empty or is being drained in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tga_truecolor_stream_decoder import tga_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic        final_byte,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [15:0]      dest_column,
	output logic [15:0]      dest_row,
	output logic [15:0]      image_width,
	output logic [15:0]      image_height,
	output logic [2:0]       status,
	output logic             last
);

	logic    in_accept;
	logic    res_valid;
	result_t res_next;
	result_t res_out;
	phase_t  phase;
	logic    free;

	assign in_ready  = free;
	assign in_accept = in_valid && in_ready;

	// Parse state and per-byte result logic
	tga_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.res_valid  (res_valid),
		.res        (res_next),
		.phase      (phase)
	);

	// Output register: a new byte is taken whenever it is empty or draining
	tga_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (in_accept),
		.load_valid (res_valid),
		.load_res   (res_next),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.free       (free),
		.res        (res_out)
	);

	assign red          = res_out.red;
	assign green        = res_out.green;
	assign blue         = res_out.blue;
	assign alpha        = res_out.alpha;
	assign dest_column  = res_out.dest_column;
	assign dest_row     = res_out.dest_row;
	assign image_width  = res_out.image_width;
	assign image_height = res_out.image_height;
	assign status       = res_out.status;
	assign last         = res_out.last;

	// A status transaction always closes the file
	`ASSERT_IMPLIES(a_status_is_last, out_valid && status != ST_PIXEL, last, "status result without last")

	// A pixel never lands outside the header width
	`ASSERT_IMPLIES(a_col_in_range, out_valid && status == ST_PIXEL, dest_column < image_width, "pixel column beyond image width")

	// Once a closing result is produced the parser stops until the next file
	`ASSERT_NEXT(a_last_ends_file, in_accept && res_valid && res_next.last, phase == PH_DONE, "file not closed after last result")

endmodule

`default_nettype wire

[tb/tga_decode_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_decode_checker
// Watches both channels of the TGA stream decoder, predicts every result from
// the accepted bytes and compares each output transaction with the oldest
// prediction.
// ----------------------------------------------------------------------------

module tga_decode_checker import tga_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic              final_byte,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [7:0]        alpha,
	input  logic [15:0]       dest_column,
	input  logic [15:0]       dest_row,
	input  logic [15:0]       image_width,
	input  logic [15:0]       image_height,
	input  logic [2:0]        status,
	input  logic              last,
	output int unsigned       error_count,
	output int unsigned       expected_left
);

	// parser copy
	phase_t      parse_phase;
	logic [4:0]  hdr_index;
	logic [7:0]  id_left;
	logic [7:0]  type_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  depth_q;
	logic        flip_rows;
	logic [15:0] col_q;
	logic [15:0] row_q;
	logic [23:0] pixel_acc;
	logic [1:0]  byte_idx;

	result_t     expected_pixels[$];

	function automatic void clear_parse_state();
		hdr_index = '0;
		id_left   = '0;
		type_q    = '0;
		width_q   = '0;
		height_q  = '0;
		depth_q   = '0;
		flip_rows = 1'b0;
		col_q     = '0;
		row_q     = '0;
		pixel_acc = '0;
		byte_idx  = '0;
	endfunction

	// status transaction, ends the file
	function automatic bit close_file(input status_t st, input bit with_dims,
			output result_t res);
		res = '0;
		res.image_width  = with_dims ? width_q : 16'd0;
		res.image_height = with_dims ? height_q : 16'd0;
		res.status       = st;
		res.last         = 1'b1;
		parse_phase      = PH_DONE;
		return 1'b1;
	endfunction

	// one accepted byte; returns 1 when it yields a result
	function automatic bit decode_tga_byte(input logic [7:0] b, input logic first,
			input logic fin, output result_t res);
		logic [2:0] per_pixel;
		res = '0;
		if (first) begin
			clear_parse_state();
			parse_phase = PH_HEADER;
		end
		case (parse_phase)
			PH_HEADER: begin
				case (hdr_index)
					HB_ID_LEN:    id_left = b;
					HB_TYPE:      type_q = b;
					HB_WIDTH_LO:  width_q[7:0] = b;
					HB_WIDTH_HI:  width_q[15:8] = b;
					HB_HEIGHT_LO: height_q[7:0] = b;
					HB_HEIGHT_HI: height_q[15:8] = b;
					HB_DEPTH:     depth_q = b;
					HB_DESC:      flip_rows = b[DESC_TOP_BIT];
					default: ;
				endcase
				hdr_index = hdr_index + 5'd1;
				if (hdr_index < HEADER_LEN)
					return fin ? close_file(ST_SHORT_HEADER, 1'b0, res) : 1'b0;
				if (type_q != TYPE_TRUECOLOR || (depth_q != DEPTH_24 && depth_q != DEPTH_32))
					return close_file(ST_UNSUPPORTED, 1'b1, res);
				if (width_q == 16'd0 || height_q == 16'd0)
					return close_file(ST_EMPTY, 1'b1, res);
				parse_phase = (id_left != 8'd0) ? PH_ID : PH_PIXELS;
				return fin ? close_file(ST_TRUNCATED, 1'b1, res) : 1'b0;
			end
			PH_ID: begin
				id_left = id_left - 8'd1;
				if (id_left == 8'd0)
					parse_phase = PH_PIXELS;
				return fin ? close_file(ST_TRUNCATED, 1'b1, res) : 1'b0;
			end
			PH_PIXELS: begin
				per_pixel = (depth_q == DEPTH_32) ? 3'd4 : 3'd3;
				if ({1'b0, byte_idx} + 3'd1 < per_pixel) begin
					if (byte_idx < 2'd3)
						pixel_acc = pixel_acc | (24'(b) << (8 * byte_idx));
					byte_idx = byte_idx + 2'd1;
					return fin ? close_file(ST_TRUNCATED, 1'b1, res) : 1'b0;
				end
				if (per_pixel == 3'd3)
					pixel_acc = pixel_acc | (24'(b) << 16);
				res.blue         = pixel_acc[7:0];
				res.green        = pixel_acc[15:8];
				res.red          = pixel_acc[23:16];
				res.alpha        = (per_pixel == 3'd4) ? b : ALPHA_OPAQUE;
				res.dest_column  = col_q;
				res.dest_row     = flip_rows ? (height_q - 16'd1 - row_q) : row_q;
				res.image_width  = width_q;
				res.image_height = height_q;
				res.status       = ST_PIXEL;
				pixel_acc = '0;
				byte_idx  = '0;
				col_q = col_q + 16'd1;
				if (col_q == width_q) begin
					col_q = '0;
					row_q = row_q + 16'd1;
				end
				if (row_q == height_q) begin
					parse_phase = PH_DONE;
					res.last = 1'b1;
					return 1'b1;
				end
				if (fin)
					return close_file(ST_TRUNCATED, 1'b1, res);
				res.last = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("rgba=%02h/%02h/%02h/%02h col=%0d row=%0d size=%0dx%0d status=%0d last=%0b",
			r.red, r.green, r.blue, r.alpha, r.dest_column, r.dest_row,
			r.image_width, r.image_height, r.status, r.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		result_t decoded;
		if (!arst_n) begin
			parse_phase = PH_IDLE;
			clear_parse_state();
			expected_pixels.delete();
			error_count = 0;
		end else begin
			// output side first: it belongs to an earlier byte
			if (out_valid && out_ready) begin
				got.red          = red;
				got.green        = green;
				got.blue         = blue;
				got.alpha        = alpha;
				got.dest_column  = dest_column;
				got.dest_row     = dest_row;
				got.image_width  = image_width;
				got.image_height = image_height;
				got.status       = status_t'(status);
				got.last         = last;
				if (expected_pixels.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: %s", describe(got));
				end else begin
					want = expected_pixels.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue || got.alpha !== want.alpha ||
							got.dest_column !== want.dest_column ||
							got.dest_row !== want.dest_row ||
							got.image_width !== want.image_width ||
							got.image_height !== want.image_height ||
							got.status !== want.status || got.last !== want.last) begin
						error_count++;
						if (error_count <= 10)
							$display("result mismatch: expected %s, got %s",
								describe(want), describe(got));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (decode_tga_byte(data_byte, first_byte, final_byte, decoded))
					expected_pixels.push_back(decoded);
			end
		end
		expected_left = expected_pixels.size();
	end

endmodule

[tb/tga_truecolor_stream_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_truecolor_stream_decoder_test
// Stimulus and verdict for the TGA true-color stream decoder: directed files
// for every header outcome and every way a file can end, then a long run of
// random files, mostly well formed, with random idling on both channels.
// ----------------------------------------------------------------------------

module tga_truecolor_stream_decoder_test;
	import tga_pkg::*;

	localparam int unsigned ITEM_TARGET    = 1550;  // input transactions in the whole run
	localparam int unsigned CALM_ITEMS     = 150;   // tail of the run without idling
	localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
	localparam int unsigned LONG_HOLD      = 400;   // receiver hold-off length
	localparam int unsigned HOLD_AFTER     = 60;    // results taken before the hold-off

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	// input channel, all driven from time zero
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        first_byte = 1'b0;
	logic        final_byte = 1'b0;

	// output channel
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] dest_column;
	logic [15:0] dest_row;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [2:0]  status;
	logic        last;

	int unsigned mismatches;
	int unsigned expected_left;

	// file under construction and bookkeeping for the sender
	logic [7:0]  file_image[$];
	int unsigned bytes_offered = 0; // every byte sent, stray ones included
	bit          quiet = 1'b0;      // set near the end: no idling on either side

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tga_truecolor_stream_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.final_byte   (final_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.dest_column  (dest_column),
		.dest_row     (dest_row),
		.image_width  (image_width),
		.image_height (image_height),
		.status       (status),
		.last         (last)
	);

	tga_decode_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.dest_column   (dest_column),
		.dest_row      (dest_row),
		.image_width   (image_width),
		.image_height  (image_height),
		.status        (status),
		.last          (last),
		.error_count   (mismatches),
		.expected_left (expected_left)
	);

	// Build a whole file in file_image: 18-byte header with random filler in
	// the fields the decoder ignores, the ID field, then npix raw pixels of
	// random content (BGR or BGRA order, depending on depth).
	function automatic void compose_file(input logic [7:0] id_len, input logic [7:0] kind,
			input logic [15:0] w, input logic [15:0] h, input logic [7:0] depth,
			input logic [7:0] desc, input int unsigned npix);
		int unsigned per_pixel;
		per_pixel = (depth == DEPTH_32) ? 4 : 3;
		file_image.delete();
		for (int i = 0; i < HEADER_LEN; i++)
			file_image.push_back(8'($urandom_range(0, 255)));
		file_image[HB_ID_LEN]    = id_len;
		file_image[HB_TYPE]      = kind;
		file_image[HB_WIDTH_LO]  = w[7:0];
		file_image[HB_WIDTH_HI]  = w[15:8];
		file_image[HB_HEIGHT_LO] = h[7:0];
		file_image[HB_HEIGHT_HI] = h[15:8];
		file_image[HB_DEPTH]     = depth;
		file_image[HB_DESC]      = desc;
		repeat (id_len) file_image.push_back(8'($urandom_range(0, 255)));
		repeat (npix * per_pixel) file_image.push_back(8'($urandom_range(0, 255)));
	endfunction

	// One input transaction. Entered just after a rising edge; returns just
	// after the edge that accepted the byte. Valid only drops for an idle
	// burst and then holds, payload steady, until in_ready is seen high.
	task automatic offer_byte(input logic [7:0] b, input logic first, input logic fin);
		int unsigned gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 9) == 0)
			gap = $urandom_range(1, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		first_byte <= first;
		final_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_offered++;
	endtask

	// Send the first cut bytes of file_image; first_byte on byte 0, final_byte
	// on the last byte sent when mark_final is set.
	task automatic stream_file(input int unsigned cut, input bit mark_final);
		if (cut > file_image.size())
			cut = file_image.size();
		for (int unsigned i = 0; i < cut; i++)
			offer_byte(file_image[i], i == 0, mark_final && (i + 1 == cut));
	endtask

	// Bytes with no first_byte: dropped after a finished file, or taken as
	// continuation of a file that was left open.
	task automatic stray_bytes(input int unsigned n);
		repeat (n) offer_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
	endtask

	// One random file. Most are well-formed and small so that pixel output
	// dominates; the rest cover every error exit and the odd huge header.
	task automatic random_file();
		int unsigned pick;
		int unsigned npix;
		int unsigned cut;
		logic [7:0]  id_len;
		logic [7:0]  kind;
		logic [7:0]  depth;
		logic [15:0] w;
		logic [15:0] h;
		bit          with_final;
		pick   = $urandom_range(0, 99);
		kind   = TYPE_TRUECOLOR;
		depth  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
		w      = 16'($urandom_range(1, 6));
		h      = 16'($urandom_range(1, 5));
		id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;
		if ($urandom_range(0, 39) == 0)
			id_len = 8'($urandom_range(0, 255));
		with_final = 1'($urandom_range(0, 1));
		npix = w * h;
		if (pick < 6) begin
			// unsupported type and/or depth
			if ($urandom_range(0, 1)) begin
				kind = 8'($urandom_range(0, 255));
				if (kind == TYPE_TRUECOLOR)
					kind = 8'd10;
			end else begin
				depth = 8'($urandom_range(0, 255));
				if (depth == DEPTH_24 || depth == DEPTH_32)
					depth = 8'd16;
			end
			npix = $urandom_range(0, 2);
		end else if (pick < 9) begin
			// empty image
			case ($urandom_range(0, 2))
				0: w = 16'd0;
				1: h = 16'd0;
				default: begin
					w = 16'd0;
					h = 16'd0;
				end
			endcase
			npix = $urandom_range(0, 2);
		end else if (pick < 12) begin
			// huge dimensions, cut short by the final byte
			w = 16'($urandom_range(256, 65535));
			h = 16'($urandom_range(1, 65535));
			npix = $urandom_range(1, 4);
			with_final = 1'b1;
		end
		compose_file(id_len, kind, w, h, depth, 8'($urandom_range(0, 255)), npix);
		cut = file_image.size();
		if (pick >= 12 && pick < 22) begin
			// truncated after the header
			cut = $urandom_range(HEADER_LEN, file_image.size() - 1);
			with_final = 1'b1;
		end else if (pick >= 22 && pick < 27) begin
			// short header
			cut = $urandom_range(1, HEADER_LEN - 1);
			with_final = 1'b1;
		end else if (pick >= 27 && pick < 32) begin
			// left open, the next first byte abandons it
			cut = $urandom_range(1, file_image.size() - 1);
			with_final = 1'b0;
		end
		stream_file(cut, with_final);
		if ($urandom_range(0, 7) == 0)
			stray_bytes($urandom_range(1, 3));
	endtask

	// Receiver: random stall bursts, one long hold-off once a few dozen
	// results have been taken (the sender keeps offering, so the output
	// register fills and in_ready drops), and no stalls in the calm tail.
	initial begin : drain
		int unsigned stall;
		int unsigned taken;
		bit          held;
		stall = 0;
		taken = 0;
		held  = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				taken++;
			if (stall == 0 && !quiet) begin
				if (!held && taken >= HOLD_AFTER) begin
					stall = LONG_HOLD;
					held  = 1'b1;
				end else if ($urandom_range(0, 7) == 0) begin
					stall = $urandom_range(1, 11);
				end
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run of cycles without any transaction on either channel
	// means the block hung or a result never came.
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n)
				idle = 0;
			else if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed files ---
		// bytes before any file: dropped
		stray_bytes(3);
		// 1x1 24-bit, final byte completes the only pixel
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 8'h00, 1);
		stream_file(file_image.size(), 1'b1);
		// 2x2 32-bit, ID field, top-left origin (rows mirrored)
		compose_file(8'd3, TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_32, 8'h20, 4);
		stream_file(file_image.size(), 1'b1);
		// ends on pixel count alone, trailing bytes dropped; other desc bits set
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd3, 16'd1, DEPTH_24, 8'hDF, 3);
		stream_file(file_image.size(), 1'b0);
		stray_bytes(4);
		// short header: final on byte 0, then final mid-header
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_24, 8'h00, 4);
		stream_file(1, 1'b1);
		stream_file(10, 1'b1);
		// unsupported type, then unsupported depth with final on the last header byte
		compose_file(8'd0, 8'd10, 16'd2, 16'd2, DEPTH_24, 8'h00, 2);
		stream_file(file_image.size(), 1'b1);
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd16, 8'h00, 4);
		stream_file(HEADER_LEN, 1'b1);
		// unsupported wins over empty; all-ones type and depth
		compose_file(8'd0, 8'hFF, 16'd0, 16'd0, 8'hFF, 8'hFF, 0);
		stream_file(HEADER_LEN, 1'b0);
		// empty: zero width with an ID field that is not waited for, zero height
		compose_file(8'd5, TYPE_TRUECOLOR, 16'd0, 16'd3, DEPTH_24, 8'h00, 0);
		stream_file(file_image.size(), 1'b0);
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd4, 16'd0, DEPTH_32, 8'h00, 0);
		stream_file(HEADER_LEN, 1'b1);
		// truncated at header end, inside the ID field, inside a pixel
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_24, 8'h00, 4);
		stream_file(HEADER_LEN, 1'b1);
		compose_file(8'd4, TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_24, 8'h00, 4);
		stream_file(HEADER_LEN + 2, 1'b1);
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_32, 8'h00, 4);
		stream_file(HEADER_LEN + 5, 1'b1);
		// final byte completes a pixel that is not the last: status replaces it
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd2, 16'd2, DEPTH_24, 8'h00, 4);
		stream_file(HEADER_LEN + 6, 1'b1);
		// file abandoned by a new first byte on a pixel boundary
		compose_file(8'd0, TYPE_TRUECOLOR, 16'd3, 16'd3, DEPTH_24, 8'h00, 9);
		stream_file(30, 1'b0);
		compose_file(8'd2, TYPE_TRUECOLOR, 16'd1, 16'd2, DEPTH_32, 8'h20, 2);
		stream_file(file_image.size(), 1'b1);
		// maximum size with mirrored rows, cut after three pixels
		compose_file(8'd0, TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_32, 8'hFF, 3);
		stream_file(file_image.size(), 1'b1);
		// longest ID field
		compose_file(8'hFF, TYPE_TRUECOLOR, 16'd2, 16'd1, DEPTH_24, 8'h20, 2);
		stream_file(file_image.size(), 1'b1);

		// --- random files, up to the byte budget of the whole run ---
		while (bytes_offered < ITEM_TARGET) begin
			if (bytes_offered + CALM_ITEMS >= ITEM_TARGET)
				quiet = 1'b1;
			random_file();
		end
		in_valid <= 1'b0;

		// drain: wait until every predicted result has been taken, then give the verdict
		@(negedge clk);
		while (expected_left != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
